// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

   // payload widths
   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int OFFSET_W = 11;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_TAB     = 8'h09;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_WRITE,
      ST_FILL,
      ST_READ
   } state_type;

endpackage

// ===== rtl/core/tcw_req_if.sv =====
interface tcw_req_if;
   import tcw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [CHAR_W-1:0]    char_code;
   logic [ATTR_W-1:0]    attribute;
   logic [INDEX_W-1:0]   cell_index;

   modport source (output valid, output op, output char_code, output attribute,
                   output cell_index, input ready);
   modport sink   (input valid, input op, input char_code, input attribute,
                   input cell_index, output ready);

endinterface

// ===== rtl/core/tcw_rsp_if.sv =====
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_W-1:0]    read_char;
   logic [ATTR_W-1:0]    read_attribute;
   logic [OFFSET_W-1:0]  cursor_offset;

   modport source (output valid, output read_char, output read_attribute,
                   output cursor_offset, input ready);
   modport sink   (input valid, input read_char, input read_attribute,
                   input cursor_offset, output ready);

endinterface

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/text_console_writer_unit.sv =====
// Items run one at a time; a plain character write is accepted, then does one store write; a read is
// accepted, then issues the store read, then returns the cell. A scroll walks the store one cell per
// cycle through the single RAM port pair, copying each cell one row up; a newline on the last row starts
// one, and a character that forces one is stored after it. Fill walks every cell once.
// Synchronous reset homes the cursor and starts a clearing pass that writes the blank
// cell to all ROWS*COLUMNS entries; no item is taken until it ends.
module text_console_writer_unit #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STEP = 4
) (
   input logic        clock,
   input logic        reset,
   tcw_req_if.sink    req_bus,
   tcw_rsp_if.source  rsp_bus
);
   import tcw_pkg::*;

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int PTR_W  = $clog2(CELLS + 1);
   localparam int COLC_W = $clog2(COLUMNS + 1);
   localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int MOD_W  = $clog2(TAB_STEP);

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [INDEX_W-1:0]   cell_ff, cell_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COLC_W-1:0]    col_ff, col_in;
   logic [MOD_W-1:0]     mod_ff, mod_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [ADDR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic                 pend_ff, pend_in;
   logic                 post_write_ff, post_write_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]    rsp_attr_ff, rsp_attr_in;
   logic [OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;

   logic                 accept;
   logic                 finish;
   logic                 is_newline;
   logic                 is_tab;
   logic [COL_W-1:0]     tab_col;
   logic [COL_W-1:0]     adj_col;
   logic                 wrap;
   logic [ROW_W-1:0]     row2;
   logic [COLC_W-1:0]    col2;
   logic [MOD_W-1:0]     mod2;
   logic                 row_low;
   logic                 at_last_row;
   logic                 cell_in_range;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [CELL_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [CELL_W-1:0]    ram_rd_data;

   function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] m);
      logic [MOD_W-1:0] r;
      if (m == MOD_W'(TAB_STEP - 1)) begin
         r = '0;
      end else begin
         r = m + 1'b1;
      end
      return r;
   endfunction

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   // cursor placement for a printable or tab code; mod_ff tracks col mod TAB_STEP
   assign is_newline    = (char_ff == CODE_NEWLINE);
   assign is_tab        = (char_ff == CODE_TAB);
   assign tab_col       = (mod_ff == '0) ? COL_W'(col_ff)
                        : COL_W'(col_ff) + COL_W'(TAB_STEP) - COL_W'(mod_ff);
   assign adj_col       = is_tab ? tab_col : COL_W'(col_ff);
   assign wrap          = (adj_col >= COL_W'(COLUMNS));
   assign row2          = wrap ? row_ff + 1'b1 : row_ff;
   assign col2          = wrap ? '0 : COLC_W'(adj_col);
   assign mod2          = (wrap || is_tab) ? '0 : mod_ff;
   assign row_low       = (row2 >= ROW_W'(ROWS - 1));
   assign at_last_row   = (row_ff >= ROW_W'(ROWS - 1));
   assign cell_in_range = (32'(cell_ff) < CELLS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == PTR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_WRITE: begin
                  if (is_newline) begin
                     state_in = at_last_row ? ST_SCROLL : ST_IDLE;
                  end else begin
                     state_in = row_low ? ST_SCROLL : ST_IDLE;
                  end
               end
               OP_FILL:  state_in = ST_FILL;
               OP_READ:  state_in = cell_in_range ? ST_READ : ST_IDLE;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_SCROLL: begin
            if (ptr_ff == PTR_W'(CELLS)) begin
               state_in = post_write_ff ? ST_WRITE : ST_IDLE;
            end
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_FILL: begin
            if (ptr_ff == PTR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      op_in         = op_ff;
      char_in       = char_ff;
      attr_in       = attr_ff;
      cell_in       = cell_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      mod_in        = mod_ff;
      ptr_in        = ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_in       = pend_ff;
      post_write_in = post_write_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_offset_in = rsp_offset_ff;
      finish        = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ptr_ff[ADDR_W-1:0];
      ram_wr_data   = BLANK_CELL;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ptr_ff[ADDR_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ptr_in    = ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_bus.op;
               char_in = req_bus.char_code;
               attr_in = req_bus.attribute;
               cell_in = req_bus.cell_index;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_WRITE: begin
                  if (is_newline) begin
                     col_in = '0;
                     mod_in = '0;
                     if (at_last_row) begin
                        // scroll first; row drops by one and advances again
                        ptr_in        = PTR_W'(COLUMNS);
                        pend_in       = 1'b0;
                        post_write_in = 1'b0;
                     end else begin
                        row_in = row_ff + 1'b1;
                        finish = 1'b1;
                     end
                  end else if (row_low) begin
                     row_in        = row2 - 1'b1;
                     col_in        = col2;
                     mod_in        = mod2;
                     ptr_in        = PTR_W'(COLUMNS);
                     pend_in       = 1'b0;
                     post_write_in = 1'b1;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ADDR_W'(32'(row2) * COLUMNS + 32'(col2));
                     ram_wr_data = {attr_ff, char_ff};
                     row_in      = row2;
                     col_in      = col2 + 1'b1;
                     mod_in      = mod_step(mod2);
                     finish      = 1'b1;
                  end
               end
               OP_FILL: begin
                  ptr_in = '0;
               end
               OP_READ: begin
                  if (cell_in_range) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(cell_ff);
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_SCROLL: begin
            // read cell i, write it one row up on the next cycle
            if (ptr_ff < PTR_W'(CELLS)) begin
               ram_rd_en = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
               wr_ptr_in = ADDR_W'(ptr_ff - PTR_W'(COLUMNS));
            end
            pend_in = (ptr_ff < PTR_W'(CELLS));
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_ptr_ff;
               ram_wr_data = ram_rd_data;
            end
            if ((ptr_ff == PTR_W'(CELLS)) && !post_write_ff) begin
               finish = 1'b1;
            end
         end
         ST_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
            ram_wr_data = {attr_ff, char_ff};
            col_in      = col_ff + 1'b1;
            mod_in      = mod_step(mod_ff);
            finish      = 1'b1;
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {attr_ff, char_ff};
            ptr_in      = ptr_ff + 1'b1;
            if (ptr_ff == PTR_W'(CELLS - 1)) begin
               finish = 1'b1;
            end
         end
         ST_READ: begin
            finish = 1'b1;
         end
         default: begin
         end
      endcase

      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = OFFSET_W'(32'(row_in) * COLUMNS + 32'(col_in));
         if (state_ff == ST_READ) begin
            rsp_char_in = ram_rd_data[CHAR_W-1:0];
            rsp_attr_in = ram_rd_data[CELL_W-1:CHAR_W];
         end else begin
            rsp_char_in = '0;
            rsp_attr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         mod_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         mod_ff       <= mod_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      char_ff       <= char_in;
      attr_ff       <= attr_in;
      cell_ff       <= cell_in;
      wr_ptr_ff     <= wr_ptr_in;
      post_write_ff <= post_write_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.read_char      = rsp_char_ff;
   assign rsp_bus.read_attribute = rsp_attr_ff;
   assign rsp_bus.cursor_offset  = rsp_offset_ff;

endmodule

// ===== rtl/core/tcw_checker.sv =====
module tcw_checker (
   input logic        clock,
   input logic        reset,
   tcw_req_if.sink    req_bus,
   tcw_rsp_if.source  rsp_bus
);
   import tcw_pkg::*;

   // reset starts the clearing pass, so no transfer right after it
   a_reset_blocks: assert property (@(posedge clock)
      reset |=> !req_bus.ready)
      else $error("request ready straight after reset");

   // one item at a time: the cycle after a transfer in is always busy
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while previous item still executing");

   // an item is only taken when the result slot is free or emptying
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("request taken with a result still stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=>
         (rsp_bus.valid && $stable(rsp_bus.cursor_offset)))
      else $error("stalled result dropped or changed");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
